// ===== hw/rtl/four_wheel_pd_speed_and_odometry_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion wrappers for the four-wheel PD speed and odometry block.
// ----------------------------------------------------------------------------
`ifndef FOUR_WHEEL_PD_SPEED_AND_ODOMETRY_DEFINES_SVH
`define FOUR_WHEEL_PD_SPEED_AND_ODOMETRY_DEFINES_SVH

// clocked check, masked while reset is asserted
`define FWPDO_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define FWPDO_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/fwpdo_pkg.sv =====
// ----------------------------------------------------------------------------
// fwpdo_pkg
// Types and constants for the four-wheel PD speed and odometry block.
// ----------------------------------------------------------------------------
package fwpdo_pkg;

	localparam int COUNT_WIDTH_DEF = 16;
	localparam int NUM_WHEELS      = 4;
	localparam int GAIN_W          = 16;
	localparam int DRIVE_W         = 15;
	localparam int ACC_W           = 48;
	localparam int DRIVE_LIMIT     = 10000;
	localparam int CFG_IDX_W       = 4;
	localparam int OUT_TDATA_W     = 208;
	localparam int OUT_USED_W      = NUM_WHEELS * DRIVE_W + 3 * ACC_W;

	// wheel distance scale, Q24 mm per count
	localparam int K_W   = 23;
	localparam logic [K_W-1:0] K_Q24 = 23'd4392258;
	localparam int X_ROUND_SHIFT = 9;

	// heading: K/582 = HK_INT + HK_NUM/HK_DEN
	localparam int HEADING_DIV = 582;
	localparam int HFRAC_GCD   = 6;
	localparam int HK_INT      = K_Q24 / HEADING_DIV;
	localparam int HK_NUM      = (K_Q24 % HEADING_DIV) / HFRAC_GCD;
	localparam int HK_DEN      = HEADING_DIV / HFRAC_GCD;
	localparam int HK_INT_W    = 13;
	localparam int HREM_W      = 7;
	localparam int HREM2_W     = 8;
	localparam int HFRAC_W     = 7;

	// reciprocal of HK_DEN for the quotient estimate
	localparam int HREC_SHIFT = 32;
	localparam int HREC_W     = 26;
	localparam logic [HREC_W-1:0] HREC = HREC_W'((64'd1 << HREC_SHIFT) / HK_DEN);

	typedef logic [HK_DEN-1:0][HFRAC_W-1:0] hfrac_tbl_t;

	// round(HK_NUM*b/HK_DEN); HK_DEN is odd so there is never a tie
	function automatic hfrac_tbl_t build_hfrac_tbl();
		hfrac_tbl_t t;
		for (int i = 0; i < HK_DEN; i++) begin
			t[i] = HFRAC_W'((2 * HK_NUM * i + HK_DEN) / (2 * HK_DEN));
		end
		return t;
	endfunction

	localparam hfrac_tbl_t HFRAC_TBL = build_hfrac_tbl();

	typedef logic [NUM_WHEELS-1:0][GAIN_W-1:0] gain_vec_t;

	// index 0 front, 1 back, 2 left, 3 right
	localparam gain_vec_t GAIN_P_RST = {16'd80, 16'd80, 16'd110, 16'd80};
	localparam gain_vec_t GAIN_D_RST = {16'd10, 16'd10, 16'd10, 16'd10};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P_FRONT = 4'd0,
		REG_GAIN_P_BACK  = 4'd1,
		REG_GAIN_P_LEFT  = 4'd2,
		REG_GAIN_P_RIGHT = 4'd3,
		REG_GAIN_D_FRONT = 4'd4,
		REG_GAIN_D_BACK  = 4'd5,
		REG_GAIN_D_LEFT  = 4'd6,
		REG_GAIN_D_RIGHT = 4'd7
	} cfg_reg_t;

	localparam int NUM_STAGES = 5;

	// per-stage load strobes of the shared pipeline
	typedef struct packed {
		logic s5;
		logic s4;
		logic s3;
		logic s2;
		logic s1;
	} pipe_ld_t;

endpackage

// ===== hw/rtl/four_wheel_pd_speed_and_odometry.sv =====
// ----------------------------------------------------------------------------
// four_wheel_pd_speed_and_odometry
// Four-wheel PD speed controller with dead-reckoning odometry.
// ----------------------------------------------------------------------------
// One control tick per transaction, one transaction per clock sustained while the output is not stalled.
// The result comes out of a five-stage pipeline (error, gain products,
// saturation / rounding, heading quotient correction, accumulate) shared
// by four PD lanes and the odometry merge; tvalid is the fifth stage's valid.
// The depth is set by the heading path, which scales by K/582 through a
// reciprocal multiply by 1/97 and a one-step remainder correction.
// A stalled output backs up stage by stage; empty stages keep filling.
// Gains are to be written through the cfg port only while no tick is in
// flight; the block itself does not enforce this.
module four_wheel_pd_speed_and_odometry #(
	parameter int COUNT_WIDTH = fwpdo_pkg::COUNT_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// count_front, count_back, count_left, count_right,
	// target_front, target_back, target_left, target_right
	input  logic [8*COUNT_WIDTH-1:0]              s_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// drive_front, drive_back, drive_left, drive_right, pos_x, pos_y,
	// heading, zero pad
	output logic [fwpdo_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [fwpdo_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [fwpdo_pkg::GAIN_W-1:0]          cfg_data
);

	localparam int NW = fwpdo_pkg::NUM_WHEELS;
	localparam int NS = fwpdo_pkg::NUM_STAGES;
	localparam int DRIVE_W = fwpdo_pkg::DRIVE_W;

	logic [NW-1:0][fwpdo_pkg::GAIN_W-1:0] gain_p_q;
	logic [NW-1:0][fwpdo_pkg::GAIN_W-1:0] gain_d_q;
	logic [NS:1]                          vld_q;
	logic [NS+1:1]                        en;
	fwpdo_pkg::pipe_ld_t                  ld;

	logic signed [DRIVE_W-1:0] drive_s3 [NW];
	logic signed [DRIVE_W-1:0] drive_s4 [NW];
	logic signed [DRIVE_W-1:0] drive_s5 [NW];
	logic signed [fwpdo_pkg::ACC_W-1:0] pos_x, pos_y, heading;

	// pipeline flow control
	always_comb begin
		en[NS+1] = m_axis_tready;
		for (int k = NS; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
		ld.s1 = s_axis_tvalid && en[1];
		ld.s2 = vld_q[1] && en[2];
		ld.s3 = vld_q[2] && en[3];
		ld.s4 = vld_q[3] && en[4];
		ld.s5 = vld_q[4] && en[5];
	end

	assign s_axis_tready = en[1];
	assign m_axis_tvalid = vld_q[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= s_axis_tvalid;
			end
			for (int k = 2; k <= NS; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// gain registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q <= fwpdo_pkg::GAIN_P_RST;
			gain_d_q <= fwpdo_pkg::GAIN_D_RST;
		end else if (cfg_valid) begin
			case (fwpdo_pkg::cfg_reg_t'(cfg_index))
				fwpdo_pkg::REG_GAIN_P_FRONT: gain_p_q[0] <= cfg_data;
				fwpdo_pkg::REG_GAIN_P_BACK:  gain_p_q[1] <= cfg_data;
				fwpdo_pkg::REG_GAIN_P_LEFT:  gain_p_q[2] <= cfg_data;
				fwpdo_pkg::REG_GAIN_P_RIGHT: gain_p_q[3] <= cfg_data;
				fwpdo_pkg::REG_GAIN_D_FRONT: gain_d_q[0] <= cfg_data;
				fwpdo_pkg::REG_GAIN_D_BACK:  gain_d_q[1] <= cfg_data;
				fwpdo_pkg::REG_GAIN_D_LEFT:  gain_d_q[2] <= cfg_data;
				fwpdo_pkg::REG_GAIN_D_RIGHT: gain_d_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// wheel lanes, 0 front, 1 back, 2 left, 3 right
	for (genvar i = 0; i < NW; i++) begin : g_lane
		fwpdo_pd_lane #(
			.COUNT_WIDTH(COUNT_WIDTH)
		) u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.ld      (ld),
			.count   ($signed(s_axis_tdata[i*COUNT_WIDTH +: COUNT_WIDTH])),
			.target  ($signed(s_axis_tdata[(NW+i)*COUNT_WIDTH +: COUNT_WIDTH])),
			.gain_p  (gain_p_q[i]),
			.gain_d  (gain_d_q[i]),
			.drive_s3(drive_s3[i])
		);

		always_ff @(posedge clk) begin
			if (ld.s4) begin
				drive_s4[i] <= drive_s3[i];
			end
			if (ld.s5) begin
				drive_s5[i] <= drive_s4[i];
			end
		end
	end

	fwpdo_odom #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_odom (
		.clk        (clk),
		.arst_n     (arst_n),
		.ld         (ld),
		.count_front($signed(s_axis_tdata[0*COUNT_WIDTH +: COUNT_WIDTH])),
		.count_back ($signed(s_axis_tdata[1*COUNT_WIDTH +: COUNT_WIDTH])),
		.count_left ($signed(s_axis_tdata[2*COUNT_WIDTH +: COUNT_WIDTH])),
		.count_right($signed(s_axis_tdata[3*COUNT_WIDTH +: COUNT_WIDTH])),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.heading    (heading)
	);

	assign m_axis_tdata = {
		(fwpdo_pkg::OUT_TDATA_W - fwpdo_pkg::OUT_USED_W)'(0),
		heading, pos_y, pos_x,
		drive_s5[3], drive_s5[2], drive_s5[1], drive_s5[0]
	};

endmodule

// ===== hw/rtl/fwpdo_pd_lane.sv =====
// ----------------------------------------------------------------------------
// fwpdo_pd_lane
// One wheel's PD speed loop: error, derivative, gain products, saturation.
// ----------------------------------------------------------------------------
module fwpdo_pd_lane #(
	parameter int COUNT_WIDTH = fwpdo_pkg::COUNT_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fwpdo_pkg::pipe_ld_t                 ld,
	input  logic signed [COUNT_WIDTH-1:0]       count,
	input  logic signed [COUNT_WIDTH-1:0]       target,
	input  logic [fwpdo_pkg::GAIN_W-1:0]        gain_p,
	input  logic [fwpdo_pkg::GAIN_W-1:0]        gain_d,
	output logic signed [fwpdo_pkg::DRIVE_W-1:0] drive_s3
);

	localparam int EW  = COUNT_WIDTH + 1;
	localparam int DW  = COUNT_WIDTH + 2;
	localparam int PPW = EW + fwpdo_pkg::GAIN_W + 1;
	localparam int PDW = DW + fwpdo_pkg::GAIN_W + 1;
	localparam int SW  = PDW + 1;
	localparam logic signed [SW-1:0] LIM = SW'(fwpdo_pkg::DRIVE_LIMIT);

	logic signed [EW-1:0]  err;
	logic signed [DW-1:0]  derr;
	logic signed [EW-1:0]  last_err_q;
	logic signed [EW-1:0]  err_s1;
	logic signed [DW-1:0]  derr_s1;
	logic signed [PPW-1:0] prod_p_s2;
	logic signed [PDW-1:0] prod_d_s2;
	logic signed [SW-1:0]  pd_sum;

	assign err  = EW'(target) - EW'(count);
	assign derr = DW'(err) - DW'(last_err_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_err_q <= '0;
		end else if (ld.s1) begin
			last_err_q <= err;
		end
	end

	always_ff @(posedge clk) begin
		if (ld.s1) begin
			err_s1  <= err;
			derr_s1 <= derr;
		end
		if (ld.s2) begin
			prod_p_s2 <= $signed({1'b0, gain_p}) * err_s1;
			prod_d_s2 <= $signed({1'b0, gain_d}) * derr_s1;
		end
		if (ld.s3) begin
			if (pd_sum > LIM) begin
				drive_s3 <= fwpdo_pkg::DRIVE_W'(fwpdo_pkg::DRIVE_LIMIT);
			end else if (pd_sum < -LIM) begin
				drive_s3 <= -fwpdo_pkg::DRIVE_W'(fwpdo_pkg::DRIVE_LIMIT);
			end else begin
				drive_s3 <= pd_sum[fwpdo_pkg::DRIVE_W-1:0];
			end
		end
	end

	assign pd_sum = SW'(prod_p_s2) + SW'(prod_d_s2);

endmodule

// ===== hw/rtl/fwpdo_odom.sv =====
// ----------------------------------------------------------------------------
// fwpdo_odom
// Merging stage: combines the four wheel counts into x, y and heading
// increments and keeps the three wrapping accumulators.
// ----------------------------------------------------------------------------
module fwpdo_odom #(
	parameter int COUNT_WIDTH = fwpdo_pkg::COUNT_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fwpdo_pkg::pipe_ld_t                 ld,
	input  logic signed [COUNT_WIDTH-1:0]       count_front,
	input  logic signed [COUNT_WIDTH-1:0]       count_back,
	input  logic signed [COUNT_WIDTH-1:0]       count_left,
	input  logic signed [COUNT_WIDTH-1:0]       count_right,
	output logic signed [fwpdo_pkg::ACC_W-1:0]  pos_x,
	output logic signed [fwpdo_pkg::ACC_W-1:0]  pos_y,
	output logic signed [fwpdo_pkg::ACC_W-1:0]  heading
);

	localparam int DXW  = COUNT_WIDTH + 1;
	localparam int HSW  = COUNT_WIDTH + 2;
	localparam int PW   = DXW + fwpdo_pkg::K_W + 1;
	localparam int RQW  = PW - fwpdo_pkg::X_ROUND_SHIFT;
	localparam int RXW  = RQW + 1;
	localparam int HRW  = HSW + fwpdo_pkg::HREC_W;
	localparam int QW   = HRW - fwpdo_pkg::HREC_SHIFT;
	localparam int HIW  = HSW + fwpdo_pkg::HK_INT_W;
	localparam int HMW  = HIW + 1;
	localparam int ACC_W = fwpdo_pkg::ACC_W;
	localparam logic [PW-1:0] X_HALF = PW'(1) << (fwpdo_pkg::X_ROUND_SHIFT - 1);

	// stage 1
	logic signed [DXW-1:0] dx_s1, dy_s1;
	logic [HSW-1:0]        hm_s1;
	logic                  hneg_s1;
	logic signed [HSW-1:0] hsum;

	// stage 2
	logic signed [PW-1:0]  px_s2, py_s2;
	logic [HRW-1:0]        hrec_s2;
	logic [HIW-1:0]        hint_s2;
	logic [HSW-1:0]        hm_s2;
	logic                  hneg_s2;

	// stage 3
	logic signed [RXW-1:0] rx_s3, ry_s3;
	logic [QW-1:0]         q_s3;
	logic [fwpdo_pkg::HREM2_W-1:0] b0_s3;
	logic [HIW-1:0]        hint_s3;
	logic                  hneg_s3;

	// stage 4
	logic signed [RXW-1:0] rx_s4, ry_s4;
	logic signed [HMW-1:0] hinc_s4;

	logic [PW-1:0]         xmag, ymag;
	logic [RQW-1:0]        xq, yq;
	logic [QW-1:0]         q_est;
	logic [HSW-1:0]        hrem_full;
	logic [QW-1:0]         a_fix;
	logic [fwpdo_pkg::HREM_W-1:0] b_fix;
	logic [HMW-1:0]        hmag;

	assign hsum = HSW'(count_front) + HSW'(count_back) + HSW'(count_left) + HSW'(count_right);

	// round half away from zero on the magnitude
	assign xmag = px_s2[PW-1] ? PW'(-px_s2) : PW'(px_s2);
	assign ymag = py_s2[PW-1] ? PW'(-py_s2) : PW'(py_s2);
	assign xq   = RQW'((xmag + X_HALF) >> fwpdo_pkg::X_ROUND_SHIFT);
	assign yq   = RQW'((ymag + X_HALF) >> fwpdo_pkg::X_ROUND_SHIFT);

	// quotient estimate is exact or one low
	assign q_est     = hrec_s2[HRW-1 -: QW];
	assign hrem_full = hm_s2 - HSW'(HSW'(q_est) * HSW'(fwpdo_pkg::HK_DEN));

	always_comb begin
		if (b0_s3 >= fwpdo_pkg::HREM2_W'(fwpdo_pkg::HK_DEN)) begin
			a_fix = q_s3 + QW'(1);
			b_fix = fwpdo_pkg::HREM_W'(b0_s3 - fwpdo_pkg::HREM2_W'(fwpdo_pkg::HK_DEN));
		end else begin
			a_fix = q_s3;
			b_fix = b0_s3[fwpdo_pkg::HREM_W-1:0];
		end
		hmag = HMW'(hint_s3) + HMW'(HMW'(a_fix) * HMW'(fwpdo_pkg::HK_NUM))
			+ HMW'(fwpdo_pkg::HFRAC_TBL[b_fix]);
	end

	always_ff @(posedge clk) begin
		if (ld.s1) begin
			dx_s1   <= DXW'(count_front) - DXW'(count_back);
			dy_s1   <= DXW'(count_right) - DXW'(count_left);
			hneg_s1 <= hsum[HSW-1];
			hm_s1   <= hsum[HSW-1] ? HSW'(-hsum) : HSW'(hsum);
		end
		if (ld.s2) begin
			px_s2   <= dx_s1 * $signed({1'b0, fwpdo_pkg::K_Q24});
			py_s2   <= dy_s1 * $signed({1'b0, fwpdo_pkg::K_Q24});
			hrec_s2 <= HRW'(hm_s1) * HRW'(fwpdo_pkg::HREC);
			hint_s2 <= HIW'(hm_s1) * HIW'(fwpdo_pkg::HK_INT);
			hm_s2   <= hm_s1;
			hneg_s2 <= hneg_s1;
		end
		if (ld.s3) begin
			rx_s3   <= px_s2[PW-1] ? -RXW'(xq) : RXW'(xq);
			ry_s3   <= py_s2[PW-1] ? -RXW'(yq) : RXW'(yq);
			q_s3    <= q_est;
			b0_s3   <= hrem_full[fwpdo_pkg::HREM2_W-1:0];
			hint_s3 <= hint_s2;
			hneg_s3 <= hneg_s2;
		end
		if (ld.s4) begin
			rx_s4   <= rx_s3;
			ry_s4   <= ry_s3;
			hinc_s4 <= hneg_s3 ? -$signed(hmag) : $signed(hmag);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x   <= '0;
			pos_y   <= '0;
			heading <= '0;
		end else if (ld.s5) begin
			pos_x   <= pos_x + ACC_W'(rx_s4);
			pos_y   <= pos_y + ACC_W'(ry_s4);
			heading <= heading - ACC_W'(hinc_s4);
		end
	end

endmodule

// ===== hw/rtl/fwpdo_checker.sv =====
// ----------------------------------------------------------------------------
// fwpdo_checker
// Port-level checks for the four-wheel PD speed and odometry block.
// ----------------------------------------------------------------------------
`include "four_wheel_pd_speed_and_odometry_defines.svh"

module fwpdo_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [fwpdo_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	`FWPDO_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "output transaction changed while stalled")
	`FWPDO_ASSERT(a_drive_range, m_axis_tvalid |-> ($signed(m_axis_tdata[14:0]) <= 15'sd10000) && ($signed(m_axis_tdata[14:0]) >= -15'sd10000) && ($signed(m_axis_tdata[29:15]) <= 15'sd10000) && ($signed(m_axis_tdata[29:15]) >= -15'sd10000) && ($signed(m_axis_tdata[44:30]) <= 15'sd10000) && ($signed(m_axis_tdata[44:30]) >= -15'sd10000) && ($signed(m_axis_tdata[59:45]) <= 15'sd10000) && ($signed(m_axis_tdata[59:45]) >= -15'sd10000), "drive outside saturation limits")
	`FWPDO_ASSERT(a_pad_zero, m_axis_tvalid |-> m_axis_tdata[fwpdo_pkg::OUT_TDATA_W-1:fwpdo_pkg::OUT_USED_W] == '0, "tdata pad bits not zero")
	`FWPDO_ASSERT_ALWAYS(a_rst_idle, !arst_n |-> !m_axis_tvalid, "output valid during reset")

endmodule

bind four_wheel_pd_speed_and_odometry fwpdo_checker u_fwpdo_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);
